/* design/spq_pkg.sv */
// Shared types and constants for the sorted-array priority queue.
// Used by the queue top level and its checker; depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] item_data;
    logic signed [31:0] item_priority;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_data;
    logic signed [31:0] removed_priority;
    logic [3:0]         fill_count;
  } spq_rsp_t;

endpackage

`default_nettype wire

/* design/spq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the queue entries; no package dependencies.
`default_nettype none

module spq_ram #(
  parameter int Width = 64,
  parameter int Depth = 8
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/sorted_array_priority_queue_top.sv */
// Sorted-array priority queue: sequencer, fill count and entry RAM.
// Depends on spq_pkg and spq_ram.
`default_nettype none

// Usage
//   A request (insert or delete) is taken at a rising edge where start is
//   high and busy is low. Exactly one response follows: done_o is high
//   for one cycle with rsp_o (status, removed entry, fill count). The
//   receiver must take it in that cycle; there is no back-pressure.
//   Entries sit in one RAM in ascending priority order, read one address
//   per cycle with registered data, and a single compare unit walks them.
//   Steps from a request to done_o:
//     rejected insert or delete, or insert into an empty queue: answered
//     from idle; delete: the top entry is read, then returned from S_POP;
//     insert: S_CMP moves each larger entry up one place and stops on a
//     smaller-or-equal key, writing the new entry there, or, at the bottom,
//     hands over to S_WRNEW, which writes it at address 0.
//   busy stays high while an insert walks the array or a delete waits on
//   the RAM read; a new request may be taken in the cycle done_o is shown.
//   Reset empties the queue at once (fill count to zero); RAM contents
//   are not cleared, since only entries below the fill count are read.
module sorted_array_priority_queue_top #(
  parameter int QueueDepth = spq_pkg::QUEUE_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  spq_pkg::spq_req_t req_i,
  output logic              done_o,
  output spq_pkg::spq_rsp_t rsp_o
);

  localparam int AW = $clog2(QueueDepth);
  localparam int OW = $clog2(QueueDepth + 1);
  localparam logic [OW-1:0] OccFull = OW'(QueueDepth);
  localparam logic [OW-1:0] OccOne  = OW'(1);
  localparam logic [OW-1:0] OccTwo  = OW'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WRNEW,
    S_POP
  } state_e;

  state_e            state_q, state_d;
  logic [OW-1:0]     occ_q, occ_d;
  logic [OW-1:0]     pos_q, pos_d;
  spq_pkg::spq_req_t req_q, req_d;
  spq_pkg::spq_rsp_t rsp_q, rsp_d;
  logic              done_q, done_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  logic [OW-1:0]      occ_m1, pos_m1, pos_m2;
  logic signed [31:0] rd_key;
  logic signed [31:0] rd_data;
  logic               key_above;

  function automatic logic [3:0] to_fill(input logic [OW-1:0] occ);
    logic [OW+3:0] wide;
    wide = {4'b0000, occ};
    return wide[3:0];
  endfunction

  assign occ_m1    = occ_q - OccOne;
  assign pos_m1    = pos_q - OccOne;
  assign pos_m2    = pos_q - OccTwo;
  assign rd_key    = ram_rdata[63:32];
  assign rd_data   = ram_rdata[31:0];
  // single compare unit: stored key strictly above the new key
  assign key_above = rd_key > req_q.item_priority;

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    pos_d     = pos_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos_q[AW-1:0];
    ram_wdata = {req_q.item_priority, req_q.item_data};
    ram_raddr = pos_m1[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          rsp_d.removed_data     = '0;
          rsp_d.removed_priority = '0;
          if (req_i.mode == spq_pkg::MODE_INSERT) begin
            if (occ_q == OccFull) begin
              done_d           = 1'b1;
              rsp_d.status     = spq_pkg::ST_FULL;
              rsp_d.fill_count = to_fill(occ_q);
            end else if (occ_q == '0) begin
              ram_we           = 1'b1;
              ram_waddr        = '0;
              ram_wdata        = {req_i.item_priority, req_i.item_data};
              occ_d            = OccOne;
              done_d           = 1'b1;
              rsp_d.status     = spq_pkg::ST_DONE;
              rsp_d.fill_count = to_fill(OccOne);
            end else begin
              pos_d     = occ_q;
              ram_raddr = occ_m1[AW-1:0];
              state_d   = S_CMP;
            end
          end else begin
            if (occ_q == '0) begin
              done_d           = 1'b1;
              rsp_d.status     = spq_pkg::ST_EMPTY;
              rsp_d.fill_count = to_fill(occ_q);
            end else begin
              ram_raddr = occ_m1[AW-1:0];
              state_d   = S_POP;
            end
          end
        end
      end

      S_CMP: begin
        ram_we = 1'b1;
        if (key_above) begin
          // move the larger entry up one place and look one lower
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
          if (pos_m1 == '0) begin
            state_d = S_WRNEW;
          end else begin
            ram_raddr = pos_m2[AW-1:0];
          end
        end else begin
          occ_d            = occ_q + OccOne;
          done_d           = 1'b1;
          rsp_d.status     = spq_pkg::ST_DONE;
          rsp_d.fill_count = to_fill(occ_q + OccOne);
          state_d          = S_IDLE;
        end
      end

      S_WRNEW: begin
        ram_we           = 1'b1;
        ram_waddr        = '0;
        occ_d            = occ_q + OccOne;
        done_d           = 1'b1;
        rsp_d.status     = spq_pkg::ST_DONE;
        rsp_d.fill_count = to_fill(occ_q + OccOne);
        state_d          = S_IDLE;
      end

      S_POP: begin
        occ_d                  = occ_m1;
        done_d                 = 1'b1;
        rsp_d.status           = spq_pkg::ST_DONE;
        rsp_d.removed_data     = rd_data;
        rsp_d.removed_priority = rd_key;
        rsp_d.fill_count       = to_fill(occ_m1);
        state_d                = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  spq_ram #(
    .Width(64),
    .Depth(QueueDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

/* design/spq_chk.sv */
// Port-level checker for the priority queue, bound to the top level.
// Depends on spq_pkg.
`default_nettype none

module spq_chk #(
  parameter int QueueDepth = spq_pkg::QUEUE_DEPTH
) (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               start,
  input wire               busy,
  input spq_pkg::spq_req_t req_i,
  input wire               done_o,
  input spq_pkg::spq_rsp_t rsp_o
);

  // an accepted request either answers next cycle or holds busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("request neither answered nor in progress");

  // rejected responses carry no removed entry
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != spq_pkg::ST_DONE) |->
      (rsp_o.removed_data == '0 && rsp_o.removed_priority == '0))
    else $error("rejected response carries entry data");

  // an empty rejection reports an empty queue
  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == spq_pkg::ST_EMPTY) |-> (rsp_o.fill_count == 4'd0))
    else $error("empty rejection with nonzero fill count");

  // fill count never exceeds capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((QueueDepth > 15) || (int'(rsp_o.fill_count) <= QueueDepth)))
    else $error("fill count above queue depth");

endmodule

bind sorted_array_priority_queue_top spq_chk #(
  .QueueDepth(QueueDepth)
) u_spq_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .req_i (req_i),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

`default_nettype wire
